/* hw/rtl/fp16_stream_argmax_unit_macros.svh */
// ---------------------------------------------------------------------------
// fp16_stream_argmax_unit_macros
// Assertion macros shared by the argmax unit.
// ---------------------------------------------------------------------------
`ifndef FP16_STREAM_ARGMAX_UNIT_MACROS_SVH
`define FP16_STREAM_ARGMAX_UNIT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define FSA_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define FSA_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`endif

/* hw/rtl/fsa_pkg.sv */
// ---------------------------------------------------------------------------
// fsa_pkg
// Shared constants and helpers of the half-precision streaming argmax.
// ---------------------------------------------------------------------------
package fsa_pkg;

    localparam int VectorLengthDefault = 1024;
    localparam int LogitWidth          = 16;
    localparam int IndexWidth          = 10;
    localparam int TdataInWidth        = 16;
    localparam int TdataOutWidth       = 16;
    localparam logic [4:0] ExpMask     = 5'h1F;

    function automatic logic half_is_nan(input logic [15:0] h);
        half_is_nan = (h[14:10] == ExpMask) && (h[9:0] != 10'd0);
    endfunction

    // Strict IEEE greater-than on raw encodings; both zeros compare equal.
    function automatic logic half_greater(input logic [15:0] a, input logic [15:0] b);
        logic signed [16:0] ka;
        logic signed [16:0] kb;
        ka = a[15] ? -$signed({2'b00, a[14:0]}) : $signed({2'b00, a[14:0]});
        kb = b[15] ? -$signed({2'b00, b[14:0]}) : $signed({2'b00, b[14:0]});
        half_greater = !half_is_nan(a) && !half_is_nan(b) && (ka > kb);
    endfunction

endpackage

/* hw/rtl/fsa_tracker.sv */
// ---------------------------------------------------------------------------
// fsa_tracker
// Holds the running best value, its position and the item counter.
// ---------------------------------------------------------------------------
`include "fp16_stream_argmax_unit_macros.svh"
module fsa_tracker #(
    parameter int VECTOR_LENGTH = fsa_pkg::VectorLengthDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [15:0] logit,
    input  logic        last,
    output logic [fsa_pkg::IndexWidth-1:0] result_index
);

    localparam int CountWidth = $clog2(VECTOR_LENGTH);
    localparam logic [CountWidth-1:0] Limit = CountWidth'(VECTOR_LENGTH - 1);

    logic [15:0]                     best_value_reg;
    logic [fsa_pkg::IndexWidth-1:0]  best_position_reg;
    logic [CountWidth-1:0]           count_reg;
    logic                            first_reg;
    logic                            take;
    logic [fsa_pkg::IndexWidth-1:0]  pos_idx;

    // The counter never passes the limit, so it is the saturated position.
    always_comb
    begin
        if (CountWidth >= fsa_pkg::IndexWidth)
            pos_idx = fsa_pkg::IndexWidth'(count_reg);
        else
            pos_idx = fsa_pkg::IndexWidth'({{fsa_pkg::IndexWidth{1'b0}}, count_reg});
        take = first_reg || fsa_pkg::half_greater(logit, best_value_reg);
        result_index = take ? pos_idx : best_position_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg         <= '0;
            first_reg         <= 1'b1;
            best_value_reg    <= '0;
            best_position_reg <= '0;
        end
        else if (step)
        begin
            if (take)
            begin
                best_value_reg    <= logit;
                best_position_reg <= pos_idx;
            end
            first_reg <= last;
            if (last)
                count_reg <= '0;
            else if (count_reg != Limit)
                count_reg <= count_reg + 1'b1;
        end
    end

    `FSA_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= Limit,
        "count past limit")
    `FSA_ASSERT_NEXT(a_last_clears, clk, rst_n, step && last,
        count_reg == '0 && first_reg, "no restart")
    `FSA_ASSERT_NEXT(a_first_take, clk, rst_n, step && first_reg,
        best_value_reg == $past(logit), "first lost")

endmodule

/* hw/rtl/fp16_stream_argmax_unit.sv */
// A result appears on the output register in the cycle after its last item is accepted.
// One item per cycle unless stalled; compare and update sit between input and result regs.
// An output register with its own valid lets input proceed while a result waits.
// Reset (rst_n, async, active low) clears the count, best value and output valid.
// ---------------------------------------------------------------------------
// fp16_stream_argmax_unit
// Streaming argmax over half-precision logits, index out on the last item.
// ---------------------------------------------------------------------------
`include "fp16_stream_argmax_unit_macros.svh"
module fp16_stream_argmax_unit #(
    parameter int VECTOR_LENGTH = fsa_pkg::VectorLengthDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] logit
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [9:0] best_index, rest zero
);

    logic        step;
    logic [fsa_pkg::IndexWidth-1:0] idx;
    logic        out_valid_reg;
    logic [fsa_pkg::IndexWidth-1:0] out_index_reg;

    // Stall only when a result is held and the next item would make another.
    assign s_axis_tready = !out_valid_reg || m_axis_tready || !s_axis_tlast;
    assign step = s_axis_tvalid && s_axis_tready;

    fsa_tracker #(.VECTOR_LENGTH(VECTOR_LENGTH)) u_tracker (
        .clk(clk), .rst_n(rst_n), .step(step), .logit(s_axis_tdata),
        .last(s_axis_tlast), .result_index(idx)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step && s_axis_tlast)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step && s_axis_tlast)
            out_index_reg <= idx;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_index_reg};

    `FSA_ASSERT_NEXT(a_hold, clk, rst_n,
        m_axis_tvalid && !m_axis_tready && !(step && s_axis_tlast),
        m_axis_tvalid, "result dropped")
    `FSA_ASSERT_IMP(a_no_overwrite, clk, rst_n,
        m_axis_tvalid && !m_axis_tready && s_axis_tlast,
        !s_axis_tready, "result overwritten")
    `FSA_ASSERT_NEXT(a_data_stable, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        $stable(m_axis_tdata), "result changed while waiting")

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Streams half-precision vectors into the argmax unit and checks each index.
// ---------------------------------------------------------------------------
module testbench;

    localparam int VecLen     = fsa_pkg::VectorLengthDefault;
    localparam int CycleLimit = 400000;

    typedef struct packed {
        logic [15:0] logit;
        logic        last;
    } logit_item_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;

    logit_item_t pending_items[$];
    logic [9:0]  expected_index[$];
    logic [15:0] best_logit;
    logic [9:0]  best_pos;
    int          next_pos;
    int          fail_count;
    int          cycle_count;
    int          calm_cycles;

    fp16_stream_argmax_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic nan_half(input logic [15:0] h);
        return (h[14:10] == 5'h1F) && (h[9:0] != 10'd0);
    endfunction

    function automatic int order_key(input logic [15:0] h);
        return h[15] ? -int'(h[14:0]) : int'(h[14:0]);
    endfunction

    // Tracks the running best and queues the index when a vector closes.
    task automatic track_argmax(input logit_item_t it);
        int pos;
        pos = (next_pos > VecLen - 1) ? VecLen - 1 : next_pos;
        if (next_pos == 0 || (!nan_half(it.logit) && !nan_half(best_logit)
                && order_key(it.logit) > order_key(best_logit)))
        begin
            best_logit = it.logit;
            best_pos   = pos[9:0];
        end
        if (it.last)
        begin
            next_pos = 0;
            expected_index.push_back(best_pos);
        end
        else if (next_pos < VecLen - 1)
        begin
            next_pos++;
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        fail_count++;
    endtask

    task automatic it_drive(input logit_item_t it);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= it.logit;
        s_axis_tlast  <= it.last;
    endtask

    task automatic add_vector(input int len, input int flavor);
        logit_item_t it;
        for (int i = 0; i < len; i++)
        begin
            it.logit = 16'($urandom);
            case (flavor)
                1: it.logit = {1'b0, 15'($urandom_range(0, 16'h3ff))};
                2: it.logit = {$urandom_range(0, 1) == 1, 15'($urandom_range(0, 3))};
                3: if ($urandom_range(0, 3) == 0)
                       it.logit = 16'h7C00 | 16'($urandom_range(1, 1023));
                default: ;
            endcase
            it.last = (i == len - 1);
            pending_items.push_back(it);
        end
    endtask

    initial
    begin
        logit_item_t it;
        int          total;
        // Directed: single items, zero pair, NaN first, infinities, subnormals.
        it = '{16'h7BFF, 1'b1}; pending_items.push_back(it);
        it = '{16'hFFFF, 1'b1}; pending_items.push_back(it);
        it = '{16'h8000, 1'b0}; pending_items.push_back(it);
        it = '{16'h0000, 1'b1}; pending_items.push_back(it);
        it = '{16'h7E00, 1'b0}; pending_items.push_back(it);
        it = '{16'h7C00, 1'b1}; pending_items.push_back(it);
        it = '{16'hFC00, 1'b0}; pending_items.push_back(it);
        it = '{16'h0001, 1'b0}; pending_items.push_back(it);
        it = '{16'h03FF, 1'b0}; pending_items.push_back(it);
        it = '{16'h0400, 1'b0}; pending_items.push_back(it);
        it = '{16'h7C01, 1'b0}; pending_items.push_back(it);
        it = '{16'h7C00, 1'b1}; pending_items.push_back(it);
        it = '{16'h5555, 1'b0}; pending_items.push_back(it);
        it = '{16'hAAAA, 1'b1}; pending_items.push_back(it);
        total = 14;
        while (total < 400)
        begin
            int len;
            len = $urandom_range(1, 12);
            add_vector(len, $urandom_range(0, 3));
            total += len;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Input side: stalls at random except during a calm window.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
            best_logit    = '0;
            best_pos      = '0;
            next_pos      = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                track_argmax({s_axis_tdata, s_axis_tlast});
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_items.size() > 0
                        && (calm_cycles > 0 || $urandom_range(0, 99) >= 24))
                begin
                    it_drive(pending_items.pop_front());
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output side: checks each accepted index against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            fail_count    = 0;
            cycle_count   = 0;
            calm_cycles   = 0;
        end
        else
        begin
            cycle_count++;
            if (cycle_count == 300) calm_cycles = 400;
            else if (calm_cycles > 0) calm_cycles--;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_index.size() == 0)
                    report_mismatch($sformatf("unexpected index %0d", m_axis_tdata));
                else
                begin
                    logic [9:0] want;
                    want = expected_index.pop_front();
                    if (m_axis_tdata !== {6'd0, want})
                        report_mismatch($sformatf("index %0d, wanted %0d",
                            m_axis_tdata, want));
                end
            end
            m_axis_tready <= (calm_cycles > 0) || ($urandom_range(0, 99) >= 24);
        end
    end

    initial
    begin
        #20;
        forever
        begin
            @(posedge clk);
            if (cycle_count > CycleLimit)
            begin
                $display("tb: failure");
                $finish;
            end
            if (pending_items.size() == 0 && !s_axis_tvalid && expected_index.size() == 0)
                break;
        end
        repeat (20) @(posedge clk);
        if (fail_count == 0 && expected_index.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
